@@ rtl/core/gpt_entry_array_parser_top_assert.svh @@
// assertion macros for the gpt entry array parser
`ifndef GPT_ENTRY_ARRAY_PARSER_TOP_ASSERT_SVH
`define GPT_ENTRY_ARRAY_PARSER_TOP_ASSERT_SVH

// checked only outside reset
`define GEAP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define GEAP_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/geap_pkg.sv @@
// shared types, constants and tables of the gpt entry array parser
`timescale 1ns / 1ps
package geap_pkg;

    localparam int DEF_MAX_ENTRIES     = 512;
    localparam int DEF_MAX_ENTRY_BYTES = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd2;

    localparam int SIZE_W  = 13;
    localparam int SLOT_W  = 10;
    localparam int CLS_W   = 3;
    localparam int LBA_W   = 64;
    localparam int PROD_W  = 45;
    localparam int FLAGS_W = 7;

    localparam logic [SIZE_W-1:0] SECTOR_MIN  = 13'd512;
    localparam logic [SIZE_W-1:0] SECTOR_MAX  = 13'd4096;
    localparam logic [SIZE_W-1:0] SECTOR_DEF  = 13'd512;
    localparam logic [SIZE_W-1:0] ENTRY_MIN   = 13'd128;
    localparam logic [SIZE_W-1:0] ENTRY_DEF   = 13'd128;
    localparam logic [SLOT_W-1:0] COUNT_DEF   = 10'd128;

    localparam int GUID_BYTES  = 16;
    localparam int FIRST_LBA_POS = 'h20;
    localparam int LAST_LBA_POS  = 'h28;
    localparam int LBA_BYTES   = 8;

    localparam logic [FLAGS_W-1:0] FLAGS_ALL = 7'h7f;
    localparam int ZERO_GUID_BIT = 6;

    localparam logic [CLS_W-1:0] CLS_BASIC    = 3'd0;
    localparam logic [CLS_W-1:0] CLS_EFI      = 3'd1;
    localparam logic [CLS_W-1:0] CLS_MSR      = 3'd2;
    localparam logic [CLS_W-1:0] CLS_RECOVERY = 3'd3;
    localparam logic [CLS_W-1:0] CLS_HFS      = 3'd4;
    localparam logic [CLS_W-1:0] CLS_LINUX    = 3'd5;
    localparam logic [CLS_W-1:0] CLS_UNKNOWN  = 3'd6;

    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 144;
    localparam int OUT_TUSER_W = 4;

    // known type guids in on-disk byte order, one row per known class
    localparam logic [7:0] GUID_TABLE [0:5][0:15] = '{
        '{8'hA2,8'hA0,8'hD0,8'hEB,8'hE5,8'hB9,8'h33,8'h44,
          8'h87,8'hC0,8'h68,8'hB6,8'hB7,8'h26,8'h99,8'hC7},
        '{8'h28,8'h73,8'h2A,8'hC1,8'h1F,8'hF8,8'hD2,8'h11,
          8'hBA,8'h4B,8'h00,8'hA0,8'hC9,8'h3E,8'hC9,8'h3B},
        '{8'h16,8'hE3,8'hC9,8'hE3,8'h5C,8'h0B,8'hB8,8'h4D,
          8'h81,8'h7D,8'hF9,8'h2D,8'hF0,8'h02,8'h15,8'hAE},
        '{8'hA4,8'hBB,8'h94,8'hDE,8'hD1,8'h06,8'h40,8'h4D,
          8'hA1,8'h6A,8'hBF,8'hD5,8'h01,8'h79,8'hD6,8'hAC},
        '{8'h00,8'h53,8'h46,8'h48,8'h00,8'h00,8'hAA,8'h11,
          8'hAA,8'h11,8'h00,8'h30,8'h65,8'h43,8'hEC,8'hAC},
        '{8'hAF,8'h3D,8'hC6,8'h0F,8'h83,8'h84,8'h72,8'h47,
          8'h8E,8'h79,8'h3D,8'h69,8'hD8,8'h47,8'h7D,8'hE4}
    };

endpackage

@@ rtl/core/gpt_entry_array_parser_top.sv @@
// gpt partition entry array parser: byte tracker and extent pipeline
//
//  channel  | dir | handshake                | payload
//  s (in)   | in  | i_s_tvalid / o_s_tready  | tdata: data_byte; tuser: table_start
//  m (out)  | out | o_m_tvalid / i_m_tready  | tdata: slot, offset, length, overflow
//  cfg      | in  | i_cfg_valid / o_cfg_ready| index, data
//
// one byte per cycle while o_s_tready is high; the parse state updates in the cycle a byte is taken
// a result passes three stages and the output register after the last byte of its entry
// (capture, class and count, multiply, carry add)
// sync reset clears parse state and all stage valids and sets config to its defaults; no clearing pass
// the result pipeline is elastic, o_s_tready drops only when its first stage is full
`timescale 1ns / 1ps
module gpt_entry_array_parser_top
    import geap_pkg::*;
#(
    parameter int MAX_ENTRIES     = DEF_MAX_ENTRIES,
    parameter int MAX_ENTRY_BYTES = DEF_MAX_ENTRY_BYTES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [7:0] data_byte
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,   // [0] table_start
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [9:0] slot_number, [73:10] byte_offset, [137:74] byte_length, [138] overflow
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic [OUT_TUSER_W-1:0] o_m_tuser,   // [2:0] type_class, [3] ntfs_candidate
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int POS_W = $clog2(MAX_ENTRY_BYTES);

    // config
    logic [SIZE_W-1:0] r_sector_size, r_entry_size;
    logic [SLOT_W-1:0] r_entry_count;

    // parse state
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [FLAGS_W-1:0] r_flags, n_flags;
    logic [LBA_W-1:0]   r_fb, n_fb, r_lb, n_lb;
    logic               r_fin, n_fin;

    logic               s_acc, start;
    logic [POS_W-1:0]   e_pos;
    logic [SLOT_W-1:0]  e_slot;
    logic [FLAGS_W-1:0] e_flags, upd_flags;
    logic [LBA_W-1:0]   e_fb, e_lb, upd_fb, upd_lb;
    logic               e_fin;
    logic [POS_W:0]     pos_inc;
    logic [SLOT_W:0]    slot_inc, ecount;
    logic [SIZE_W-1:0]  esize, ss;
    logic               is_last, a_load;
    logic [7:0]         in_byte;

    // result pipeline
    logic               r_a_valid, r_b_valid, r_c_valid, r_o_valid;
    logic               a_ready, b_ready, c_ready, o_ready;
    logic [SLOT_W-1:0]  r_a_slot, r_b_slot, r_c_slot, r_o_slot;
    logic [FLAGS_W-1:0] r_a_flags;
    logic [LBA_W-1:0]   r_a_fb, r_a_lb, r_b_fb, r_b_cnt;
    logic [SIZE_W-1:0]  r_a_ss, r_b_ss;
    logic [CLS_W-1:0]   a_cls, r_b_cls, r_c_cls, r_o_cls;
    logic               a_skip;
    logic [PROD_W-1:0]  r_c_off_lo, r_c_off_hi, r_c_len_lo, r_c_len_hi;
    logic               r_c_cnt_zero;
    logic [PROD_W:0]    off_mid, len_mid;
    logic [LBA_W-1:0]   r_o_off, r_o_len;
    logic               r_o_ovf;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_size <= SECTOR_DEF;
            r_entry_size  <= ENTRY_DEF;
            r_entry_count <= COUNT_DEF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SECTOR_SIZE: r_sector_size <= i_cfg_data;
                CFG_ENTRY_SIZE:  r_entry_size  <= i_cfg_data;
                CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data[SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective limits
    always_comb begin
        if (r_entry_size < ENTRY_MIN) begin
            esize = ENTRY_MIN;
        end else if (r_entry_size > SIZE_W'(MAX_ENTRY_BYTES)) begin
            esize = SIZE_W'(MAX_ENTRY_BYTES);
        end else begin
            esize = r_entry_size;
        end
        ecount = {1'b0, r_entry_count};
        if (ecount == '0) begin
            ecount = (SLOT_W+1)'(1);
        end else if (ecount > (SLOT_W+1)'(MAX_ENTRIES)) begin
            ecount = (SLOT_W+1)'(MAX_ENTRIES);
        end
        if (r_sector_size < SECTOR_MIN || r_sector_size > SECTOR_MAX) begin
            ss = SECTOR_DEF;
        end else begin
            ss = r_sector_size;
        end
    end

    assign s_acc   = i_s_tvalid && o_s_tready;
    assign start   = i_s_tuser[0];
    assign in_byte = i_s_tdata[7:0];

    // a start word sees a cleared array
    assign e_pos   = start ? '0 : r_pos;
    assign e_slot  = start ? '0 : r_slot;
    assign e_flags = start ? FLAGS_ALL : r_flags;
    assign e_fb    = start ? '0 : r_fb;
    assign e_lb    = start ? '0 : r_lb;
    assign e_fin   = start ? 1'b0 : r_fin;

    always_comb begin
        upd_flags = e_flags;
        upd_fb    = e_fb;
        upd_lb    = e_lb;
        if (e_pos < POS_W'(GUID_BYTES)) begin
            for (int k = 0; k < ZERO_GUID_BIT; k++) begin
                if (in_byte != GUID_TABLE[k][e_pos[3:0]]) begin
                    upd_flags[k] = 1'b0;
                end
            end
            if (in_byte != 8'd0) begin
                upd_flags[ZERO_GUID_BIT] = 1'b0;
            end
        end else if (e_pos >= POS_W'(FIRST_LBA_POS) && e_pos < POS_W'(LAST_LBA_POS)) begin
            upd_fb[{e_pos[2:0], 3'b000} +: 8] = in_byte;
        end else if (e_pos >= POS_W'(LAST_LBA_POS)
                     && e_pos < POS_W'(LAST_LBA_POS + LBA_BYTES)) begin
            upd_lb[{e_pos[2:0], 3'b000} +: 8] = in_byte;
        end
    end

    assign pos_inc  = {1'b0, e_pos} + (POS_W+1)'(1);
    assign slot_inc = {1'b0, e_slot} + (SLOT_W+1)'(1);
    assign is_last  = !(SIZE_W'(pos_inc) < esize);
    assign a_load   = s_acc && !e_fin && is_last;

    always_comb begin
        n_pos   = r_pos;
        n_slot  = r_slot;
        n_flags = r_flags;
        n_fb    = r_fb;
        n_lb    = r_lb;
        n_fin   = r_fin;
        if (s_acc && !e_fin) begin
            if (is_last) begin
                n_pos   = '0;
                n_flags = FLAGS_ALL;
                n_fb    = '0;
                n_lb    = '0;
                n_slot  = slot_inc[SLOT_W-1:0];
                n_fin   = (slot_inc >= ecount);
            end else begin
                n_pos   = pos_inc[POS_W-1:0];
                n_flags = upd_flags;
                n_fb    = upd_fb;
                n_lb    = upd_lb;
                n_slot  = e_slot;
                n_fin   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_slot  <= '0;
            r_flags <= FLAGS_ALL;
            r_fb    <= '0;
            r_lb    <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_slot  <= n_slot;
            r_flags <= n_flags;
            r_fb    <= n_fb;
            r_lb    <= n_lb;
            r_fin   <= n_fin;
        end
    end

    // stage ready chain
    assign o_ready    = !r_o_valid || i_m_tready;
    assign c_ready    = !r_c_valid || o_ready;
    assign b_ready    = !r_b_valid || c_ready;
    assign a_ready    = !r_a_valid || b_ready;
    assign o_s_tready = a_ready;

    // class and drop decision
    always_comb begin
        a_cls = CLS_UNKNOWN;
        for (int k = ZERO_GUID_BIT - 1; k >= 0; k--) begin
            if (r_a_flags[k]) begin
                a_cls = CLS_W'(k);
            end
        end
        a_skip = (a_cls == CLS_UNKNOWN && r_a_flags[ZERO_GUID_BIT]) || (r_a_lb < r_a_fb);
    end

    assign off_mid = (PROD_W+1)'(r_c_off_hi) + (PROD_W+1)'(r_c_off_lo[PROD_W-1:32]);
    assign len_mid = (PROD_W+1)'(r_c_len_hi) + (PROD_W+1)'(r_c_len_lo[PROD_W-1:32]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= a_load;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid && !a_skip;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
            if (o_ready) begin
                r_o_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && a_load) begin
            r_a_slot  <= slot_inc[SLOT_W-1:0];
            r_a_flags <= upd_flags;
            r_a_fb    <= upd_fb;
            r_a_lb    <= upd_lb;
            r_a_ss    <= ss;
        end
        if (b_ready && r_a_valid) begin
            r_b_slot <= r_a_slot;
            r_b_cls  <= a_cls;
            r_b_fb   <= r_a_fb;
            r_b_cnt  <= r_a_lb - r_a_fb + LBA_W'(1);
            r_b_ss   <= r_a_ss;
        end
        if (c_ready && r_b_valid) begin
            r_c_slot     <= r_b_slot;
            r_c_cls      <= r_b_cls;
            r_c_off_lo   <= PROD_W'(r_b_fb[31:0]) * PROD_W'(r_b_ss);
            r_c_off_hi   <= PROD_W'(r_b_fb[63:32]) * PROD_W'(r_b_ss);
            r_c_len_lo   <= PROD_W'(r_b_cnt[31:0]) * PROD_W'(r_b_ss);
            r_c_len_hi   <= PROD_W'(r_b_cnt[63:32]) * PROD_W'(r_b_ss);
            r_c_cnt_zero <= (r_b_cnt == '0);
        end
        if (o_ready && r_c_valid) begin
            r_o_slot <= r_c_slot;
            r_o_cls  <= r_c_cls;
            r_o_off  <= {off_mid[31:0], r_c_off_lo[31:0]};
            r_o_len  <= {len_mid[31:0], r_c_len_lo[31:0]};
            r_o_ovf  <= (|off_mid[PROD_W:32]) || (|len_mid[PROD_W:32]) || r_c_cnt_zero;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {(OUT_TDATA_W - SLOT_W - 2*LBA_W - 1)'(0),
                         r_o_ovf, r_o_len, r_o_off, r_o_slot};
    assign o_m_tuser  = {(r_o_cls == CLS_BASIC || r_o_cls == CLS_RECOVERY), r_o_cls};

endmodule

@@ rtl/core/geap_checker.sv @@
// port-level assertions for the gpt entry array parser, bound to the top level
`timescale 1ns / 1ps
`include "gpt_entry_array_parser_top_assert.svh"
module geap_checker
    import geap_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic [IN_TDATA_W-1:0]  i_s_tdata,
    input logic [IN_TUSER_W-1:0]  i_s_tuser,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic [OUT_TUSER_W-1:0] o_m_tuser,
    input logic                   i_cfg_valid,
    input logic                   o_cfg_ready,
    input logic [CFG_IDX_W-1:0]   i_cfg_index,
    input logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // stalled word stays put
    `GEAP_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "output word changed under stall")

    // ntfs flag follows the class
    `GEAP_ASSERT_RST(a_ntfs_class, i_clk, i_rst_n, o_m_tvalid |-> (o_m_tuser[3] == (o_m_tuser[2:0] == CLS_BASIC || o_m_tuser[2:0] == CLS_RECOVERY)), "ntfs flag disagrees with class")

    // nothing comes out right after reset
    `GEAP_ASSERT_ALL(a_rst_quiet, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

endmodule

bind gpt_entry_array_parser_top geap_checker u_geap_checker (.*);

@@ tb/gpt_entry_array_parser_top_test.sv @@
// self-checking testbench for the gpt partition entry array parser
`timescale 1ns / 1ps
module gpt_entry_array_parser_top_test
    import geap_pkg::*;
;
    localparam int OFF_LSB = SLOT_W;
    localparam int LEN_LSB = OFF_LSB + LBA_W;
    localparam int OVF_BIT = LEN_LSB + LBA_W;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES = 20;
    localparam int TIMEOUT_NS = 24_000_000;
    localparam int MAX_REPORTS = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [LBA_W-1:0] LBA_ONES = '1;
    localparam logic [LBA_W-1:0] LBA_2P52 = 64'h0010_0000_0000_0000;

    typedef enum int {
        GK_BASIC = 0, GK_EFI = 1, GK_MSR = 2, GK_RECOVERY = 3, GK_HFS = 4, GK_LINUX = 5,
        GK_ZERO = 6, GK_RANDOM = 7, GK_NEAR_KNOWN = 8, GK_NEAR_ZERO = 9
    } guid_kind_e;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [CLS_W-1:0]  cls;
        logic              ntfs;
        logic [LBA_W-1:0]  offset;
        logic [LBA_W-1:0]  length;
        logic              ovf;
    } extent_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic [IN_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // parser state as predicted
    int cfg_sector = SECTOR_DEF;
    int cfg_entry_size = ENTRY_DEF;
    int cfg_entry_count = COUNT_DEF;
    int pos = 0;
    int slot_cnt = 0;
    logic [FLAGS_W-1:0] guid_flags = FLAGS_ALL;
    logic [LBA_W-1:0] cur_first = '0;
    logic [LBA_W-1:0] cur_last = '0;
    logic arr_done = 1'b0;

    extent_t extent_q[$];
    int extents_predicted = 0;
    int error_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;

    gpt_entry_array_parser_top dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata(s_tdata),     // [7:0] data_byte
        .i_s_tuser(s_tuser),     // [0] table_start
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata(m_tdata),     // [9:0] slot, [73:10] offset, [137:74] length, [138] overflow
        .o_m_tuser(m_tuser),     // [2:0] type_class, [3] ntfs_candidate
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic clear_entry_state();
        pos = 0;
        guid_flags = FLAGS_ALL;
        cur_first = '0;
        cur_last = '0;
    endtask

    function automatic int eff_entry_size();
        if (cfg_entry_size < ENTRY_MIN) return ENTRY_MIN;
        if (cfg_entry_size > DEF_MAX_ENTRY_BYTES) return DEF_MAX_ENTRY_BYTES;
        return cfg_entry_size;
    endfunction

    function automatic int eff_entry_count();
        if (cfg_entry_count < 1) return 1;
        if (cfg_entry_count > DEF_MAX_ENTRIES) return DEF_MAX_ENTRIES;
        return cfg_entry_count;
    endfunction

    task automatic predict_extent(input logic [7:0] b, input logic st);
        int ss, slot, k;
        logic [FLAGS_W-1:0] eflags;
        logic [LBA_W-1:0] efirst, elast, count;
        logic [LBA_W+SIZE_W-1:0] p_off, p_len;
        extent_t e;
        if (st) begin
            clear_entry_state();
            slot_cnt = 0;
            arr_done = 1'b0;
        end
        if (arr_done) return;
        ss = (cfg_sector < SECTOR_MIN || cfg_sector > SECTOR_MAX) ? SECTOR_DEF : cfg_sector;
        if (pos < GUID_BYTES) begin
            for (k = 0; k < 6; k++)
                if (b != GUID_TABLE[k][pos]) guid_flags[k] = 1'b0;
            if (b != 8'h00) guid_flags[ZERO_GUID_BIT] = 1'b0;
        end else if (pos >= FIRST_LBA_POS && pos < FIRST_LBA_POS + LBA_BYTES) begin
            cur_first = cur_first | (LBA_W'(b) << (8 * (pos - FIRST_LBA_POS)));
        end else if (pos >= LAST_LBA_POS && pos < LAST_LBA_POS + LBA_BYTES) begin
            cur_last = cur_last | (LBA_W'(b) << (8 * (pos - LAST_LBA_POS)));
        end
        if (pos + 1 < eff_entry_size()) begin
            pos = (pos + 1) & 'hFFF;
            return;
        end
        eflags = guid_flags;
        efirst = cur_first;
        elast = cur_last;
        slot = slot_cnt + 1;
        slot_cnt = slot & 'h3FF;
        if (slot >= eff_entry_count()) arr_done = 1'b1;
        clear_entry_state();
        e.cls = CLS_UNKNOWN;
        for (k = 5; k >= 0; k--)
            if (eflags[k]) e.cls = CLS_W'(k);
        if (e.cls == CLS_UNKNOWN && eflags[ZERO_GUID_BIT]) return;
        if (elast < efirst) return;
        p_off = {{SIZE_W{1'b0}}, efirst} * (LBA_W + SIZE_W)'(ss);
        count = elast - efirst + 1;
        p_len = {{SIZE_W{1'b0}}, count} * (LBA_W + SIZE_W)'(ss);
        e.slot = SLOT_W'(slot);
        e.ntfs = (e.cls == CLS_BASIC || e.cls == CLS_RECOVERY);
        e.offset = p_off[LBA_W-1:0];
        e.length = p_len[LBA_W-1:0];
        e.ovf = (|p_off[LBA_W+SIZE_W-1:LBA_W]) || (|p_len[LBA_W+SIZE_W-1:LBA_W]) || count == 0;
        extent_q.push_back(e);
        extents_predicted++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic st);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do begin
                @(posedge clk);
            end while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= st;
        do begin
            @(posedge clk);
        end while (!s_tready);
        predict_extent(b, st);
    endtask

    // stop sending and wait until every predicted extent has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        while (extent_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SECTOR_SIZE) cfg_sector = val;
        else if (idx == CFG_ENTRY_SIZE) cfg_entry_size = val;
        else if (idx == CFG_ENTRY_COUNT) cfg_entry_count = val[SLOT_W-1:0];
    endtask

    function automatic logic [127:0] build_guid(input guid_kind_e kind);
        logic [127:0] g;
        int row, at, i;
        g = '0;
        at = $urandom_range(15);
        case (kind)
            GK_ZERO: g = '0;
            GK_RANDOM: g = {$urandom, $urandom, $urandom, $urandom};
            GK_NEAR_ZERO: g[8*at +: 8] = $urandom_range(1, 255);
            default: begin
                row = (kind == GK_NEAR_KNOWN) ? $urandom_range(5) : int'(kind);
                for (i = 0; i < GUID_BYTES; i++) g[8*i +: 8] = GUID_TABLE[row][i];
                if (kind == GK_NEAR_KNOWN) g[8*at +: 8] = g[8*at +: 8] ^ 8'($urandom_range(1, 255));
            end
        endcase
        return g;
    endfunction

    function automatic guid_kind_e random_kind();
        int r;
        r = $urandom_range(99);
        if (r < 60) return guid_kind_e'($urandom_range(0, 5));
        if (r < 72) return GK_ZERO;
        if (r < 80) return GK_RANDOM;
        if (r < 92) return GK_NEAR_KNOWN;
        return GK_NEAR_ZERO;
    endfunction

    function automatic logic [LBA_W-1:0] pick_lba();
        case ($urandom_range(5))
            0: return LBA_W'($urandom_range(0, 100000));
            1: return {$urandom, $urandom};
            2: return LBA_ONES;
            3: return '0;
            4: return (LBA_W'(1) << $urandom_range(40, 63)) + LBA_W'($urandom_range(0, 255));
            default: return {32'($urandom_range(0, 15)), $urandom};
        endcase
    endfunction

    function automatic logic [LBA_W-1:0] pick_last(input logic [LBA_W-1:0] first);
        case ($urandom_range(6))
            0, 1: return first + LBA_W'($urandom_range(0, 5000));
            2: return first - LBA_W'($urandom_range(1, 100));
            3: return first;
            4: return LBA_ONES;
            5: return {$urandom, $urandom};
            default: return first + LBA_W'($urandom);
        endcase
    endfunction

    task automatic send_span(input logic [127:0] guid, input logic [LBA_W-1:0] first_lba,
            input logic [LBA_W-1:0] last_lba, input logic st, input int from_pos, input int nbytes);
        logic [7:0] b;
        int p;
        for (p = from_pos; p < from_pos + nbytes; p++) begin
            if (p < GUID_BYTES) b = guid[8*p +: 8];
            else if (p >= FIRST_LBA_POS && p < FIRST_LBA_POS + LBA_BYTES)
                b = first_lba[8*(p-FIRST_LBA_POS) +: 8];
            else if (p >= LAST_LBA_POS && p < LAST_LBA_POS + LBA_BYTES)
                b = last_lba[8*(p-LAST_LBA_POS) +: 8];
            else b = $urandom;
            send_byte(b, st && p == from_pos);
        end
    endtask

    task automatic send_entry(input guid_kind_e kind, input logic [LBA_W-1:0] first_lba,
            input logic [LBA_W-1:0] last_lba, input logic st);
        send_span(build_guid(kind), first_lba, last_lba, st, 0, eff_entry_size());
    endtask

    task automatic test_no_start_after_reset();
        send_entry(GK_BASIC, 64'd2048, 64'd4095, 1'b0);
        send_entry(GK_LINUX, 64'd4096, 64'd8191, 1'b0);
    endtask

    task automatic test_type_classes();
        int k;
        for (k = GK_BASIC; k <= GK_NEAR_ZERO; k++)
            send_entry(guid_kind_e'(k), LBA_W'(34 + 100 * k), LBA_W'(133 + 100 * k), k == GK_BASIC);
        // last below first, single block, full range, largest, lba zero
        send_entry(GK_LINUX, 64'd1000, 64'd999, 1'b0);
        send_entry(GK_HFS, 64'd77, 64'd77, 1'b0);
        send_entry(GK_EFI, '0, LBA_ONES, 1'b0);
        send_entry(GK_RECOVERY, LBA_ONES, LBA_ONES, 1'b0);
        send_entry(GK_MSR, '0, '0, 1'b0);
    endtask

    task automatic test_sector_sizes();
        int k;
        int sizes[7] = '{4096, 4097, 511, 0, 8191, 1000, 512};
        for (k = 0; k < 7; k++) begin
            write_reg(CFG_SECTOR_SIZE, sizes[k]);
            send_entry(GK_MSR, LBA_2P52, LBA_2P52 + 7, 1'b1);
            send_entry(GK_BASIC, LBA_2P52 - 1, LBA_2P52 + 64'd100, 1'b0);
        end
    endtask

    task automatic test_entry_sizes();
        write_reg(CFG_SPARE, 13'h1FFF);
        write_reg(CFG_ENTRY_SIZE, 0);
        send_entry(GK_EFI, 64'd40, 64'd1063, 1'b1);
        write_reg(CFG_ENTRY_SIZE, 127);
        send_entry(GK_EFI, 64'd41, 64'd1064, 1'b1);
        write_reg(CFG_ENTRY_SIZE, 129);
        send_entry(GK_LINUX, 64'd42, 64'd1065, 1'b1);
        send_entry(GK_HFS, 64'd43, 64'd1066, 1'b0);
        write_reg(CFG_SECTOR_SIZE, 4096);
        write_reg(CFG_ENTRY_SIZE, 4096);
        send_entry(GK_RECOVERY, LBA_2P52, LBA_ONES, 1'b1);
        write_reg(CFG_ENTRY_SIZE, 13'h1FFF);
        send_entry(GK_BASIC, 64'd2048, 64'd999_999, 1'b1);
        write_reg(CFG_SECTOR_SIZE, 512);
        write_reg(CFG_ENTRY_SIZE, 128);
    endtask

    task automatic test_entry_counts();
        int k;
        write_reg(CFG_ENTRY_COUNT, 0);
        send_entry(GK_BASIC, 64'd10, 64'd20, 1'b1);
        send_entry(GK_BASIC, 64'd30, 64'd40, 1'b0);
        write_reg(CFG_ENTRY_COUNT, 3);
        for (k = 0; k < 4; k++) send_entry(GK_EFI, LBA_W'(k), LBA_W'(k + 9), k == 0);
        write_reg(CFG_ENTRY_COUNT, 10'h3FF);
        for (k = 0; k < DEF_MAX_ENTRIES + 1; k++)
            send_entry((k % 100 == 0 || k >= DEF_MAX_ENTRIES - 2) ? GK_LINUX : GK_ZERO,
                LBA_W'(k), LBA_W'(k + 1), k == 0);
        write_reg(CFG_ENTRY_COUNT, DEF_MAX_ENTRIES);
        send_entry(GK_HFS, 64'd5, 64'd6, 1'b1);
    endtask

    task automatic test_mid_array_changes();
        logic [127:0] g;
        int k;
        g = build_guid(GK_HFS);
        write_reg(CFG_ENTRY_SIZE, 512);
        send_span(g, 64'd300, 64'd400, 1'b1, 0, 200);
        write_reg(CFG_ENTRY_SIZE, 128);
        send_span(g, 64'd300, 64'd400, 1'b0, 200, 1);
        send_entry(GK_BASIC, 64'd500, 64'd600, 1'b0);
        write_reg(CFG_ENTRY_COUNT, 8);
        for (k = 0; k < 4; k++) send_entry(GK_MSR, LBA_W'(k), LBA_W'(k + 3), k == 0);
        write_reg(CFG_ENTRY_COUNT, 2);
        send_entry(GK_MSR, 64'd50, 64'd60, 1'b0);
        send_entry(GK_MSR, 64'd70, 64'd80, 1'b0);
    endtask

    task automatic test_output_backpressure();
        int k;
        logic [LBA_W-1:0] first;
        write_reg(CFG_ENTRY_COUNT, 64);
        hold_req = 3000;
        for (k = 0; k < 24; k++) begin
            first = pick_lba();
            send_entry(guid_kind_e'($urandom_range(0, 5)), first, pick_last(first), k == 0);
        end
        settle();
    endtask

    task automatic run_random_array();
        int n, k, roll;
        logic need_start;
        logic [CFG_DATA_W-1:0] v;
        logic [LBA_W-1:0] first;
        roll = $urandom_range(99);
        v = roll < 30 ? 512 : roll < 50 ? 4096 : roll < 80 ? $urandom_range(512, 4096)
            : $urandom_range(0, 8191);
        write_reg(CFG_SECTOR_SIZE, v);
        roll = $urandom_range(99);
        v = roll < 65 ? 128 : roll < 78 ? 256 : roll < 88 ? $urandom_range(129, 700)
            : roll < 97 ? $urandom_range(0, 127) : $urandom_range(4096, 8191);
        write_reg(CFG_ENTRY_SIZE, v);
        roll = $urandom_range(99);
        if (eff_entry_size() > 1024) v = 1;
        else v = roll < 80 ? $urandom_range(1, 6) : roll < 90 ? 0 : $urandom_range(0, 1023);
        write_reg(CFG_ENTRY_COUNT, v);
        n = (eff_entry_count() > 6 ? 6 : eff_entry_count()) + $urandom_range(0, 1);
        need_start = ($urandom_range(9) != 0);
        for (k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (roll < 7) begin
                // noise with stray start flags
                repeat ($urandom_range(1, 300)) send_byte($urandom, $urandom_range(49) == 0);
                need_start = 1'b1;
            end else if (roll < 12) begin
                // entry cut short by a restart
                send_span(build_guid(random_kind()), pick_lba(), pick_lba(), need_start, 0,
                    $urandom_range(1, eff_entry_size() - 1));
                need_start = 1'b1;
            end else begin
                first = pick_lba();
                send_entry(random_kind(), first, pick_last(first), need_start);
                need_start = 1'b0;
            end
        end
    endtask

    task automatic test_random_phase(input int send_idle, input int recv_stall);
        int base;
        settle();
        idle_pct = send_idle;
        stall_pct = recv_stall;
        base = extents_predicted;
        while (extents_predicted - base < 12) run_random_array();
    endtask

    always @(posedge clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin : check_extents
        extent_t got, want;
        if (rst_n && m_tvalid && m_tready) begin
            got.slot = m_tdata[SLOT_W-1:0];
            got.offset = m_tdata[OFF_LSB +: LBA_W];
            got.length = m_tdata[LEN_LSB +: LBA_W];
            got.ovf = m_tdata[OVF_BIT];
            got.cls = m_tuser[CLS_W-1:0];
            got.ntfs = m_tuser[CLS_W];
            if (extent_q.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected extent: slot %0d class %0d offset %h length %h",
                        got.slot, got.cls, got.offset, got.length);
            end else begin
                want = extent_q.pop_front();
                if (got.slot !== want.slot || got.cls !== want.cls || got.ntfs !== want.ntfs ||
                        got.offset !== want.offset || got.length !== want.length ||
                        got.ovf !== want.ovf) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"extent mismatch (got/want): slot %0d/%0d class %0d/%0d ",
                            "ntfs %0b/%0b offset %h/%h length %h/%h ovf %0b/%0b"},
                            got.slot, want.slot, got.cls, want.cls, got.ntfs, want.ntfs,
                            got.offset, want.offset, got.length, want.length,
                            got.ovf, want.ovf);
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_start_after_reset();
        test_type_classes();
        test_sector_sizes();
        test_entry_sizes();
        test_entry_counts();
        test_mid_array_changes();
        test_output_backpressure();
        test_random_phase(0, 0);
        test_random_phase(83, 0);
        test_random_phase(0, 83);
        test_random_phase(38, 38);
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("** gpt_entry_array_parser_top: PASSED **");
        end else begin
            $display("** gpt_entry_array_parser_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("** gpt_entry_array_parser_top: FAILED **");
        $finish;
    end

endmodule

@@ gpt_entry_array_parser_top.f @@
+incdir+rtl/core
rtl/core/geap_pkg.sv
rtl/core/gpt_entry_array_parser_top.sv
rtl/core/geap_checker.sv
tb/gpt_entry_array_parser_top_test.sv
